// ===== sv/gunifrac_pkg.sv =====
// package for the generalized unifrac pair distance block
// holds payload structs and fixed-point constants; no dependencies
package gunifrac_pkg;

  localparam int FracBits  = 16;
  localparam int AccWidth  = 56;
  localparam int FracW     = 17;
  localparam int LenW      = 24;
  localparam int SumW      = 18;
  localparam int SqrtW     = 17;
  localparam int WeightW   = 26;
  localparam int SqrtSteps = 17;

  typedef struct packed {
    logic [FracW-1:0] sample_a_fraction;
    logic [FracW-1:0] sample_b_fraction;
    logic [LenW-1:0]  branch_length;
    logic             last_branch;
  } gunifrac_in_t;

  typedef struct packed {
    logic [FracW-1:0] dist_unweighted;
    logic [FracW-1:0] dist_half;
    logic [FracW-1:0] dist_full;
    logic             no_branches;
  } gunifrac_out_t;

endpackage

// ===== sv/generalized_unifrac_pair_distance.sv =====
// top level of the generalized unifrac pair distance block
// depends on gunifrac_pkg; serial divide, square root and multiply steps
// a non-empty branch runs the divide, root, multiply, weighting and accumulate steps before
// the next branch is accepted; a last branch then runs the ratio step and waits for output,
//   an empty last one skips to ratio; an empty branch that is not last is taken every cycle
// reset: asynchronous active low, clears the accumulators and control state
module generalized_unifrac_pair_distance
  import gunifrac_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  gunifrac_in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output gunifrac_out_t out_data_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_SQRT, S_MUL, S_NMUL, S_ACC, S_RATIO, S_OUT
  } state_e;

  state_e state_q;
  logic [5:0] cnt_q;
  logic [1:0] sel_q;
  logic last_q;
  logic [SumW-1:0] s_q;
  logic [LenW-1:0] len_q;
  // divider: remainder and quotient
  logic [SumW:0] rem_q;
  logic [FracW-1:0] ad_q;
  logic [FracW-1:0] diff_q;
  // root: radicand, remainder, root
  logic [SumW+FracBits-1:0] rad_q;
  logic [SqrtW+2:0] srem_q;
  logic [SqrtW:0] root_q;
  // multiplier: multiplicand shifts, product accumulates
  logic [SqrtW+LenW:0] p5_q, p1_q;
  logic [WeightW-1:0] w0_q, w5_q, w1_q;
  logic [WeightW+FracW:0] n0_q, n5_q, n1_q;
  logic [AccWidth-1:0] num_q [3];
  logic [AccWidth-1:0] den_q [3];
  logic [AccWidth:0] rrem_q;
  logic [FracW-1:0] rq_q;
  logic [FracW-1:0] dist_q [3];
  gunifrac_out_t out_q;
  logic nb_q;

  logic [SumW:0] div_try;
  logic [SqrtW+2:0] srem_sh, strial;
  logic [AccWidth:0] rnext;

  function automatic logic [AccWidth-1:0] sat_add(logic [AccWidth-1:0] a,
                                                  logic [AccWidth-1:0] b);
    logic [AccWidth:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[AccWidth] ? {AccWidth{1'b1}} : t[AccWidth-1:0];
  endfunction

  assign div_try = {rem_q[SumW-1:0], ad_q[FracW-1]};
  assign srem_sh = {srem_q[SqrtW:0], rad_q[SumW+FracBits-1 -: 2]};
  assign strial  = {root_q, 2'b01};
  assign rnext   = {rrem_q[AccWidth-1:0], 1'b0};

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      sel_q   <= '0;
      last_q  <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        num_q[i] <= '0;
        den_q[i] <= '0;
      end
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            s_q    <= SumW'(in_data_i.sample_a_fraction) + SumW'(in_data_i.sample_b_fraction);
            ad_q   <= (in_data_i.sample_a_fraction > in_data_i.sample_b_fraction) ?
                      in_data_i.sample_a_fraction - in_data_i.sample_b_fraction :
                      in_data_i.sample_b_fraction - in_data_i.sample_a_fraction;
            len_q  <= in_data_i.branch_length;
            last_q <= in_data_i.last_branch;
            rem_q  <= '0;
            diff_q <= '0;
            cnt_q  <= '0;
            if (in_data_i.sample_a_fraction == '0 && in_data_i.sample_b_fraction == '0) begin
              state_q <= in_data_i.last_branch ? S_RATIO : S_IDLE;
              sel_q   <= '0;
            end else begin
              state_q <= S_DIV;
            end
          end
        end
        S_DIV: begin
          // restoring division of ad*2^F by s, one quotient bit per cycle
          if (div_try >= {1'b0, s_q}) begin
            rem_q <= div_try - {1'b0, s_q};
          end else begin
            rem_q <= div_try;
          end
          diff_q <= {diff_q[FracW-2:0], (div_try >= {1'b0, s_q})};
          ad_q   <= {ad_q[FracW-2:0], 1'b0};
          if (cnt_q == 6'(FracBits + FracW - 1)) begin
            state_q <= S_SQRT;
            cnt_q   <= '0;
            rad_q   <= {s_q, {FracBits{1'b0}}};
            srem_q  <= '0;
            root_q  <= '0;
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end
        S_SQRT: begin
          // two radicand bits per cycle, one root bit
          if (srem_sh >= strial) begin
            srem_q <= srem_sh - strial;
            root_q <= {root_q[SqrtW-1:0], 1'b1};
          end else begin
            srem_q <= srem_sh;
            root_q <= {root_q[SqrtW-1:0], 1'b0};
          end
          rad_q <= {rad_q[SumW+FracBits-3:0], 2'b00};
          if (cnt_q == 6'(SqrtSteps - 1)) begin
            state_q <= S_MUL;
            cnt_q   <= '0;
            p5_q    <= '0;
            p1_q    <= '0;
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end
        S_MUL: begin
          // shift-add over the length bits, lsb first
          if (len_q[cnt_q[4:0]]) begin
            p5_q <= p5_q + ((SqrtW+LenW+1)'(root_q[SqrtW-1:0]) << cnt_q[4:0]);
            p1_q <= p1_q + ((SqrtW+LenW+1)'(s_q) << cnt_q[4:0]);
          end
          if (cnt_q == 6'(LenW - 1)) begin
            state_q <= S_NMUL;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end
        S_NMUL: begin
          if (cnt_q == '0) begin
            w0_q <= WeightW'(len_q);
            w5_q <= WeightW'(p5_q >> FracBits);
            w1_q <= WeightW'(p1_q >> FracBits);
            n0_q <= '0;
            n5_q <= '0;
            n1_q <= '0;
            cnt_q <= 6'd1;
          end else begin
            // diff * w, one diff bit per cycle
            if (diff_q[cnt_q[4:0] - 5'd1]) begin
              n0_q <= n0_q + ((WeightW+FracW+1)'(w0_q) << (cnt_q[4:0] - 5'd1));
              n5_q <= n5_q + ((WeightW+FracW+1)'(w5_q) << (cnt_q[4:0] - 5'd1));
              n1_q <= n1_q + ((WeightW+FracW+1)'(w1_q) << (cnt_q[4:0] - 5'd1));
            end
            cnt_q <= cnt_q + 6'd1;
            if (cnt_q == 6'(FracW)) begin
              state_q <= S_ACC;
            end
          end
        end
        S_ACC: begin
          num_q[0] <= sat_add(num_q[0], AccWidth'(n0_q >> FracBits));
          num_q[1] <= sat_add(num_q[1], AccWidth'(n5_q >> FracBits));
          num_q[2] <= sat_add(num_q[2], AccWidth'(n1_q >> FracBits));
          den_q[0] <= sat_add(den_q[0], AccWidth'(w0_q));
          den_q[1] <= sat_add(den_q[1], AccWidth'(w5_q));
          den_q[2] <= sat_add(den_q[2], AccWidth'(w1_q));
          sel_q    <= '0;
          cnt_q    <= '0;
          state_q  <= last_q ? S_RATIO : S_IDLE;
        end
        S_RATIO: begin
          if (cnt_q == '0) begin
            rrem_q <= {1'b0, num_q[sel_q]};
            rq_q   <= '0;
            cnt_q  <= 6'd1;
          end else if (cnt_q <= 6'(FracBits)) begin
            if (rnext >= {1'b0, den_q[sel_q]}) begin
              rrem_q <= rnext - {1'b0, den_q[sel_q]};
              rq_q   <= {rq_q[FracW-2:0], 1'b1};
            end else begin
              rrem_q <= rnext;
              rq_q   <= {rq_q[FracW-2:0], 1'b0};
            end
            cnt_q <= cnt_q + 6'd1;
          end else begin
            priority if (den_q[sel_q] == '0) begin
              dist_q[sel_q] <= '0;
            end else if (num_q[sel_q] >= den_q[sel_q]) begin
              dist_q[sel_q] <= FracW'(1) << FracBits;
            end else begin
              dist_q[sel_q] <= rq_q;
            end
            cnt_q <= '0;
            if (sel_q == 2'd2) begin
              state_q <= S_OUT;
            end else begin
              sel_q <= sel_q + 2'd1;
            end
          end
        end
        S_OUT: begin
          if (out_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (state_q == S_RATIO && sel_q == 2'd2 && cnt_q == 6'(FracBits + 1)) begin
        for (int i = 0; i < 3; i++) begin
          num_q[i] <= '0;
          den_q[i] <= '0;
        end
      end
    end
  end

  always_comb begin
    out_q.dist_unweighted = dist_q[0];
    out_q.dist_half       = dist_q[1];
    out_q.dist_full       = dist_q[2];
    out_q.no_branches     = (dist_q[0] == '0) && (dist_q[1] == '0) && (dist_q[2] == '0)
                            && nb_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nb_q <= 1'b0;
    end else if (state_q == S_RATIO && sel_q == 2'd0 && cnt_q == '0) begin
      nb_q <= (den_q[0] == '0) && (den_q[1] == '0) && (den_q[2] == '0);
    end
  end

  a_ready_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped");
  a_nb_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.no_branches |-> out_data_o.dist_full == '0)
    else $error("empty pair with distance");

endmodule

// ===== tb/sv/testbench.sv =====
// testbench for the generalized unifrac pair distance block
// drives branch transactions through valid/ready, predicts distances in fixed point
// depends on gunifrac_pkg and generalized_unifrac_pair_distance
`timescale 1ns / 1ps
module testbench
  import gunifrac_pkg::*;
();

  localparam int StallLimit = 20000;
  localparam int NumRandom  = 830;
  localparam int DrainWait  = 200;

  typedef struct {
    logic [16:0] a;
    logic [16:0] b;
    logic [23:0] len;
    logic        last;
    logic        typed;
    logic [16:0] d0;
    logic [16:0] d5;
    logic [16:0] d1;
    logic        nb;
  } branch_row_t;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_ready_o;
  gunifrac_in_t  in_data_i;
  logic          out_valid_o;
  logic          out_ready_i;
  gunifrac_out_t out_data_o;

  logic [63:0] num_unw, den_unw, num_hlf, den_hlf, num_ful, den_ful;
  gunifrac_out_t expected_dists[$];
  int  failures;
  int  idle_cycles;
  int  pairs_seen;
  int  branches_sent;
  bit  stimulus_done;
  bit  hold_off;

  branch_row_t directed[$];

  generalized_unifrac_pair_distance u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [63:0] sat_sum(logic [63:0] acc, logic [63:0] x);
    logic [63:0] top;
    top = (64'd1 << AccWidth) - 1;
    if (acc > top) acc = top;
    if (x > top - acc) return top;
    return acc + x;
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v = v - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] weigh_diff(logic [63:0] d, logic [63:0] w);
    logic [63:0] lowmask;
    lowmask = (64'd1 << FracBits) - 1;
    return d * (w >> FracBits) + ((d * (w & lowmask)) >> FracBits);
  endfunction

  function automatic logic [16:0] dist_ratio(logic [63:0] num, logic [63:0] den);
    logic [63:0] q, rem;
    if (den == 0) return '0;
    if (num >= den) begin
      q = 64'd1 << FracBits;
    end else begin
      q = 0;
      rem = num;
      for (int i = 0; i < FracBits; i++) begin
        if (rem >= den - rem) begin
          rem = rem - (den - rem);
          q = (q << 1) | 64'd1;
        end else begin
          rem = rem + rem;
          q = q << 1;
        end
      end
    end
    return (q > 64'h1FFFF) ? 17'h1FFFF : q[16:0];
  endfunction

  function automatic void clear_sums();
    num_unw = 0; den_unw = 0; num_hlf = 0; den_hlf = 0; num_ful = 0; den_ful = 0;
  endfunction

  function automatic void accumulate_branch(gunifrac_in_t br);
    logic [63:0] s, ad, diff, sqs, w0, w5, w1;
    gunifrac_out_t res;
    s = 64'(br.sample_a_fraction) + 64'(br.sample_b_fraction);
    if (s != 0) begin
      ad = (br.sample_a_fraction > br.sample_b_fraction) ?
           64'(br.sample_a_fraction - br.sample_b_fraction) :
           64'(br.sample_b_fraction - br.sample_a_fraction);
      diff = (ad << FracBits) / s;
      sqs = root_floor(s << FracBits);
      w0 = 64'(br.branch_length);
      w5 = (w0 * sqs) >> FracBits;
      w1 = (w0 * s) >> FracBits;
      num_unw = sat_sum(num_unw, weigh_diff(diff, w0));
      den_unw = sat_sum(den_unw, w0);
      num_hlf = sat_sum(num_hlf, weigh_diff(diff, w5));
      den_hlf = sat_sum(den_hlf, w5);
      num_ful = sat_sum(num_ful, weigh_diff(diff, w1));
      den_ful = sat_sum(den_ful, w1);
    end
    if (br.last_branch) begin
      res.dist_unweighted = dist_ratio(num_unw, den_unw);
      res.dist_half       = dist_ratio(num_hlf, den_hlf);
      res.dist_full       = dist_ratio(num_ful, den_ful);
      res.no_branches     = (den_unw == 0 && den_hlf == 0 && den_ful == 0);
      expected_dists.push_back(res);
      clear_sums();
    end
  endfunction

  function automatic void add_row(logic [16:0] a, logic [16:0] b, logic [23:0] len,
                                  logic last, logic typed = 0, logic [16:0] d0 = 0,
                                  logic [16:0] d5 = 0, logic [16:0] d1 = 0, logic nb = 0);
    branch_row_t r;
    r.a = a; r.b = b; r.len = len; r.last = last; r.typed = typed;
    r.d0 = d0; r.d5 = d5; r.d1 = d1; r.nb = nb;
    directed.push_back(r);
  endfunction

  function automatic logic [16:0] rand_frac();
    unique case ($urandom_range(0, 5))
      0: return '0;
      1: return 17'd65536;
      2: return 17'($urandom_range(0, 16));
      3: return 17'(65536 - $urandom_range(0, 16));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [23:0] rand_len();
    unique case ($urandom_range(0, 4))
      0: return '0;
      1: return 24'hFFFFFF;
      2: return 24'($urandom_range(0, 255));
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic send_branch(gunifrac_in_t br);
    int gap;
    gap = $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_data_i  <= br;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    accumulate_branch(br);
    branches_sent++;
  endtask

  // sender
  initial begin
    gunifrac_in_t br;
    failures = 0; pairs_seen = 0; branches_sent = 0;
    stimulus_done = 0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    clear_sums();
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty pair straight after reset
    add_row(0, 0, 24'hFFFFFF, 1, 1, 0, 0, 0, 1);
    // identical fractions give zero distance
    add_row(17'd65536, 17'd65536, 24'hFFFFFF, 1, 1, 0, 0, 0, 0);
    // one sample absent gives full distance
    add_row(17'd65536, 0, 24'h010000, 1, 1, 17'd65536, 17'd65536, 17'd65536, 0);
    add_row(0, 17'd65536, 24'hFFFFFF, 1, 1, 17'd65536, 17'd65536, 17'd65536, 0);
    add_row(0, 1, 24'd1, 1);
    // zero length weights, no_branches clear only when a weight is non-zero
    add_row(17'd100, 17'd200, 24'd0, 1);
    // multi branch pair ending on an empty branch
    add_row(17'd30000, 17'd10000, 24'h020000, 0);
    add_row(17'd1, 17'd65536, 24'h000100, 0);
    add_row(17'h1FFFF & 17'd65535, 17'd2, 24'hABCDEF, 0);
    add_row(0, 0, 24'h123456, 1);
    add_row(17'd12345, 17'd54321, 24'h00FFFF, 0);
    add_row(17'd65536, 17'd65536, 24'hFFFFFF, 0);
    add_row(17'd1, 17'd1, 24'd1, 1);
    add_row(0, 0, 24'd0, 0);
    add_row(0, 0, 24'd0, 1, 1, 0, 0, 0, 1);
    add_row(17'd5, 17'd0, 24'd3, 1);

    foreach (directed[i]) begin
      br.sample_a_fraction = directed[i].a;
      br.sample_b_fraction = directed[i].b;
      br.branch_length     = directed[i].len;
      br.last_branch       = directed[i].last;
      if (directed[i].typed) begin
        // overwrite predictor entry with the value read straight off the definition
        send_branch(br);
        expected_dists[$].dist_unweighted = directed[i].d0;
        expected_dists[$].dist_half       = directed[i].d5;
        expected_dists[$].dist_full       = directed[i].d1;
        expected_dists[$].no_branches     = directed[i].nb;
      end else begin
        send_branch(br);
      end
    end

    // random pairs of 1 to 8 branches, a few long ones
    begin
      int left, plen;
      left = NumRandom;
      while (left > 0) begin
        plen = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
        for (int k = 0; k < plen && left > 0; k++) begin
          br.sample_a_fraction = rand_frac();
          br.sample_b_fraction = rand_frac();
          if ($urandom_range(0, 15) == 0) begin
            br.sample_a_fraction = '0;
            br.sample_b_fraction = '0;
          end
          br.branch_length = rand_len();
          br.last_branch   = (k == plen - 1) || (left == 1);
          send_branch(br);
          left--;
        end
      end
    end
    in_valid_i <= 1'b0;
    stimulus_done = 1;
  end

  // receiver, with one long hold-off so the block backs up
  initial begin
    int gap;
    out_ready_i = 1'b0;
    hold_off = 0;
    @(posedge rst_ni);
    forever begin
      if (pairs_seen >= 40 && !hold_off) begin
        hold_off = 1;
        out_ready_i <= 1'b0;
        repeat (3000) @(posedge clk_i);
      end
      gap = $urandom_range(0, 14);
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      pairs_seen++;
      if (expected_dists.size() == 0) begin
        $error("distance transaction with nothing expected");
        failures++;
      end else begin
        gunifrac_out_t e;
        e = expected_dists.pop_front();
        if (out_data_o.dist_unweighted !== e.dist_unweighted) begin
          $error("dist_unweighted: expected %0d, got %0d", e.dist_unweighted,
                 out_data_o.dist_unweighted);
          failures++;
        end
        if (out_data_o.dist_half !== e.dist_half) begin
          $error("dist_half: expected %0d, got %0d", e.dist_half, out_data_o.dist_half);
          failures++;
        end
        if (out_data_o.dist_full !== e.dist_full) begin
          $error("dist_full: expected %0d, got %0d", e.dist_full, out_data_o.dist_full);
          failures++;
        end
        if (out_data_o.no_branches !== e.no_branches) begin
          $error("no_branches: expected %0d, got %0d", e.no_branches,
                 out_data_o.no_branches);
          failures++;
        end
      end
    end
  end

  // watchdog and end of run
  initial begin
    idle_cycles = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("Test completed with failures");
        $finish;
      end
      if (stimulus_done && expected_dists.size() == 0) begin
        repeat (DrainWait) @(posedge clk_i);
        $display("covered %0d branch transactions and %0d pair distances",
                 branches_sent, pairs_seen);
        if (failures == 0 && expected_dists.size() == 0) begin
          $display("Test completed successfully");
        end else begin
          $display("Test completed with failures");
        end
        $finish;
      end
    end
  end

endmodule
